// ===== rtl/ole_pkg.sv =====
// ole_pkg: command, error and state codes plus item and entry types for the list engine
package ole_pkg;

  // field widths fixed by the item layout
  localparam int unsigned IdW    = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned SlotW  = 5;
  localparam int unsigned WhereW = 4;
  localparam int unsigned CountW = 5;

  // command codes; the two spare codes are refused
  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_RM_AT     = 3'd3,
    CMD_RM_ID     = 3'd4,
    CMD_FIND      = 3'd5
  } cmd_e;

  // result error codes
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_POS      = 3'd1,
    ERR_NOTFOUND = 3'd2,
    ERR_FULL     = 3'd3,
    ERR_CMD      = 3'd4
  } err_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT
  } state_e;

  // one input item
  typedef struct packed {
    cmd_e                     command;
    logic signed [IdW-1:0]    key_id;
    logic [StatW-1:0]         entry_state;
    logic [SlotW-1:0]         slot;
  } item_t;

  // one result item
  typedef struct packed {
    err_e              error;
    logic [WhereW-1:0] where;
    logic [CountW-1:0] count;
  } result_t;

  // one stored list entry
  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [StatW-1:0] status;
  } entry_t;

endpackage

// ===== rtl/ole_ram.sv =====
// ole_ram: generic simple dual-port ram with registered read
module ole_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ordered_list_engine_core.sv =====
// ordered_list_engine_core: packed ordered list of id/status entries held in one ram
//
//   channel  | signals              | handshake
//   ---------+----------------------+---------------------------------------
//   command  | start, busy, item_i  | item taken when start high, busy low
//   result   | done_o, result_o     | one-cycle strobe, no back-pressure
//
// Failed checks give their result the cycle after the item is taken, busy stays low.
// Otherwise busy is high while the ram is walked, one read and one write a cycle, and
// the result comes in the same cycle that busy falls. Insert at p moves fill-p entries,
// remove at p moves fill-p-1; a search reads from entry 0 upwards until it hits k or
// the list ends, and remove by id then moves fill-k-1. Reset empties the list at once;
// no receiver stall.
module ordered_list_engine_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ole_pkg::item_t  item_i,
  output logic            done_o,
  output ole_pkg::result_t result_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > ole_pkg::SlotW) ? CW : ole_pkg::SlotW;
  localparam int unsigned EW = $bits(ole_pkg::entry_t);

  // control state
  ole_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;

  // working registers
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [ole_pkg::IdW-1:0]   key_q, key_d;
  logic [ole_pkg::StatW-1:0] stat_q, stat_d;
  ole_pkg::cmd_e    cmd_q, cmd_d;
  logic             up_q, up_d;
  ole_pkg::result_t res_q, res_d;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  ole_pkg::entry_t  ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  ole_pkg::entry_t  ram_rdata;
  logic [EW-1:0]    ram_rdata_raw;

  // shared conditions
  logic             accept;
  logic [XW-1:0]    fill_x;
  logic [XW-1:0]    slot_x;
  logic [XW-1:0]    ins_pos_x;
  logic             ins_bad_pos;
  logic             list_full;
  logic             slot_bad;
  logic             hit;
  logic             drained;
  logic [CW-1:0]    fill_inc;
  logic [CW-1:0]    fill_dec;

  ole_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = ole_pkg::entry_t'(ram_rdata_raw);

  // handshake and command checks
  assign busy        = (state_q != ole_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign fill_x      = XW'(fill_q);
  assign slot_x      = XW'(item_i.slot);
  assign ins_pos_x   = (item_i.command == ole_pkg::CMD_INS_FRONT) ? '0 :
                       (item_i.command == ole_pkg::CMD_INS_BACK)  ? fill_x : slot_x;
  assign ins_bad_pos = ins_pos_x > fill_x;
  assign list_full   = fill_q == CW'(CAPACITY);
  assign slot_bad    = slot_x >= fill_x;
  assign hit         = pend_q && (ram_rdata.id == key_q);
  assign drained     = (rem_q == '0) && !pend_q;
  assign fill_inc    = fill_q + CW'(1);
  assign fill_dec    = fill_q - CW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ole_pkg::ST_IDLE: begin
        if (accept) begin
          case (item_i.command)
            ole_pkg::CMD_INS_FRONT, ole_pkg::CMD_INS_BACK, ole_pkg::CMD_INS_AT: begin
              if (!ins_bad_pos && !list_full) begin
                state_d = ole_pkg::ST_SHIFT;
              end
            end
            ole_pkg::CMD_RM_AT: begin
              if (!slot_bad) begin
                state_d = ole_pkg::ST_SHIFT;
              end
            end
            ole_pkg::CMD_RM_ID, ole_pkg::CMD_FIND: begin
              state_d = ole_pkg::ST_SEARCH;
            end
            default: begin
              state_d = ole_pkg::ST_IDLE;
            end
          endcase
        end
      end
      ole_pkg::ST_SEARCH: begin
        if (hit) begin
          state_d = (cmd_q == ole_pkg::CMD_RM_ID) ? ole_pkg::ST_SHIFT : ole_pkg::ST_IDLE;
        end else if (drained) begin
          state_d = ole_pkg::ST_IDLE;
        end
      end
      ole_pkg::ST_SHIFT: begin
        if (drained) begin
          state_d = ole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ole_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, ram control and result
  always_comb begin
    fill_d      = fill_q;
    pend_d      = 1'b0;
    done_d      = 1'b0;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    pend_addr_d = pend_addr_q;
    pos_d       = pos_q;
    key_d       = key_q;
    stat_d      = stat_q;
    cmd_d       = cmd_q;
    up_d        = up_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = pend_addr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = ptr_q;

    unique case (state_q)
      ole_pkg::ST_IDLE: begin
        if (accept) begin
          key_d  = item_i.key_id;
          stat_d = item_i.entry_state;
          cmd_d  = item_i.command;
          res_d  = '{error: ole_pkg::ERR_OK, where: '0, count: 5'(fill_q)};
          case (item_i.command)
            ole_pkg::CMD_INS_FRONT, ole_pkg::CMD_INS_BACK, ole_pkg::CMD_INS_AT: begin
              if (ins_bad_pos) begin
                res_d.error = ole_pkg::ERR_POS;
                done_d      = 1'b1;
              end else if (list_full) begin
                res_d.error = ole_pkg::ERR_FULL;
                done_d      = 1'b1;
              end else begin
                // open the gap from the top entry downwards
                pos_d = AW'(ins_pos_x);
                rem_d = fill_q - CW'(ins_pos_x);
                ptr_d = AW'(fill_dec);
                up_d  = 1'b1;
              end
            end
            ole_pkg::CMD_RM_AT: begin
              if (slot_bad) begin
                res_d.error = ole_pkg::ERR_POS;
                done_d      = 1'b1;
              end else begin
                // close the gap from just above the slot upwards
                pos_d = AW'(item_i.slot);
                rem_d = fill_dec - CW'(slot_x);
                ptr_d = AW'(slot_x + XW'(1));
                up_d  = 1'b0;
              end
            end
            ole_pkg::CMD_RM_ID, ole_pkg::CMD_FIND: begin
              ptr_d = '0;
              rem_d = fill_q;
            end
            default: begin
              res_d.error = ole_pkg::ERR_CMD;
              done_d      = 1'b1;
            end
          endcase
        end
      end

      ole_pkg::ST_SEARCH: begin
        if (hit) begin
          pos_d = pend_addr_q;
          if (cmd_q == ole_pkg::CMD_RM_ID) begin
            ptr_d = pend_addr_q + AW'(1);
            rem_d = fill_dec - CW'(pend_addr_q);
            up_d  = 1'b0;
          end else begin
            res_d  = '{error: ole_pkg::ERR_OK, where: 4'(pend_addr_q), count: 5'(fill_q)};
            done_d = 1'b1;
          end
        end else if (drained) begin
          res_d  = '{error: ole_pkg::ERR_NOTFOUND, where: '0, count: 5'(fill_q)};
          done_d = 1'b1;
        end else if (rem_q != '0) begin
          // walk upwards, compare in the next cycle
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q;
          ptr_d       = ptr_q + AW'(1);
          rem_d       = rem_q - CW'(1);
        end
      end

      ole_pkg::ST_SHIFT: begin
        // write back the entry read last cycle
        if (pend_q) begin
          ram_we = 1'b1;
        end
        if (rem_q != '0) begin
          ram_re      = 1'b1;
          pend_d      = 1'b1;
          rem_d       = rem_q - CW'(1);
          pend_addr_d = up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
          ptr_d       = up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
        end else if (!pend_q) begin
          // shift finished: place the new entry or drop the count
          if (up_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos_q;
            ram_wdata = '{id: key_q, status: stat_q};
            fill_d    = fill_inc;
            res_d     = '{error: ole_pkg::ERR_OK, where: 4'(pos_q), count: 5'(fill_inc)};
          end else begin
            fill_d    = fill_dec;
            res_d     = '{error: ole_pkg::ERR_OK, where: 4'(pos_q), count: 5'(fill_dec)};
          end
          done_d = 1'b1;
        end
      end

      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ole_pkg::ST_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    rem_q       <= rem_d;
    pend_addr_q <= pend_addr_d;
    pos_q       <= pos_d;
    key_q       <= key_d;
    stat_q      <= stat_d;
    cmd_q       <= cmd_d;
    up_q        <= up_d;
    res_q       <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
